// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the lexer engine RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define CSL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`else
`define CSL_ASSERT(lbl, clk, rst, prop)
`define CSL_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/csl_pkg.sv -----
// Types, constants and pattern tables of the lexer.
package csl_pkg;

   localparam int REPLAY_DEPTH = 32;
   localparam int NUM_KINDS    = 83;
   localparam int NUM_LITS     = 78;
   localparam int RC_W         = $clog2(REPLAY_DEPTH + 1);
   localparam int BUF_AW       = $clog2(REPLAY_DEPTH + 2);
   localparam int BUF_DEPTH    = 1 << BUF_AW;
   localparam int NUM_VARS     = 24;

   // input item codes
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_EOI  = 1'b1;

   // result error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UNMATCH  = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   // token kinds used by name
   localparam logic [6:0] KIND_EOF    = 7'd0;
   localparam logic [6:0] KIND_BLANK  = 7'd78;
   localparam logic [6:0] KIND_IDENT  = 7'd79;
   localparam logic [6:0] KIND_INT    = 7'd80;
   localparam logic [6:0] KIND_STRING = 7'd81;
   localparam logic [6:0] KIND_CHAR   = 7'd82;

   // bits of the variable-content patterns
   localparam int V_ID_S  = 0;
   localparam int V_ID_B  = 1;
   localparam int V_IN_S  = 2;
   localparam int V_IN_B  = 3;
   localparam int V_CH_S  = 4;
   localparam int V_CH_Q  = 5;
   localparam int V_CH_A  = 6;
   localparam int V_CH_D  = 7;
   localparam int V_ST_S  = 8;
   localparam int V_ST_B  = 9;
   localparam int V_ST_D  = 10;
   localparam int V_ST_E  = 11;
   localparam int V_ST_O1 = 12;
   localparam int V_ST_O2 = 13;
   localparam int V_ST_X  = 14;
   localparam int V_ST_XM = 15;
   localparam int V_ST_U  = 16;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  token_kind;
      logic [15:0] token_length;
      logic [31:0] end_offset;
      logic [1:0]  is_error;
      logic [7:0]  bad_byte;
      logic        last;
   } rsp_item_type;

   // literal text, right aligned, first character highest
   function automatic logic [63:0] lit_str(input int k);
      logic [63:0] s;
      s = '0;
      unique case (k)
         1: s = "(";   2: s = ")";   3: s = "{";   4: s = "}";
         5: s = "[";   6: s = "]";   7: s = "<";   8: s = ">";
         9: s = "*";   10: s = "+";  11: s = "-";  12: s = "~";
         13: s = "/";  14: s = "\\"; 15: s = "%";  16: s = "^";
         17: s = "|";  18: s = "&";  19: s = "!";  20: s = ";";
         21: s = ":";  22: s = ",";  23: s = ".";  24: s = "=";
         25: s = "?";  26: s = "->"; 27: s = "++"; 28: s = "--";
         29: s = "<<"; 30: s = ">>"; 31: s = "<="; 32: s = ">=";
         33: s = "=="; 34: s = "!="; 35: s = "&&"; 36: s = "||";
         37: s = "*="; 38: s = "/="; 39: s = "%="; 40: s = "+=";
         41: s = "-="; 42: s = "<<="; 43: s = ">>="; 44: s = "&=";
         45: s = "^="; 46: s = "|="; 47: s = "...";
         48: s = "break";   49: s = "case";    50: s = "continue";
         51: s = "default"; 52: s = "char";    53: s = "do";
         54: s = "else";    55: s = "enum";    56: s = "extern";
         57: s = "float";   58: s = "for";     59: s = "goto";
         60: s = "if";      61: s = "int";     62: s = "long";
         63: s = "open";    64: s = "closed";  65: s = "return";
         66: s = "short";   67: s = "signed";  68: s = "sizeof";
         69: s = "static";  70: s = "struct";  71: s = "switch";
         72: s = "union";   73: s = "unsigned"; 74: s = "void";
         75: s = "volatile"; 76: s = "while";
         77: s = 64'h0a;
         78: s = " ";
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] lit_len(input int k);
      logic [63:0] s;
      logic [3:0]  n;
      s = lit_str(k);
      n = '0;
      for (int i = 0; i < 8; i++) begin
         if (s[i*8 +: 8] != 8'h00) n = 4'(i + 1);
      end
      return n;
   endfunction

   function automatic logic [7:0] lit_byte(input int k, input logic [2:0] p);
      logic [63:0] s;
      logic [3:0]  idx;
      s   = lit_str(k);
      idx = lit_len(k) - 4'd1 - {1'b0, p};
      return s[idx[2:0]*8 +: 8];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ----- hw/rtl/c_subset_lexer_unit.sv -----
// Top level of the maximal munch lexer: input queue and token engine.
// The engine takes the next item from the queue only after it has finished the last one;
// bytes replayed from the byte buffer, tokens given at the end of an attempt and unmatched
// bytes add to the work done for a source byte.
// Results pass through a hold stage and leave through an output register.
// Reset (synchronous, active high) clears queue, engine state and offsets.
module c_subset_lexer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csl_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csl_pkg::rsp_item_type rsp_item
);
   import csl_pkg::*;

   logic         q_valid, q_pop;
   req_item_type q_item;

   csl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   csl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- hw/rtl/csl_ram.sv -----
// Generic single write port RAM with registered read.
module csl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/csl_front.sv -----
// Front end: accepts items into a two-entry queue for the engine.
module csl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csl_pkg::req_item_type req_item,
   output logic                  q_valid,
   output csl_pkg::req_item_type q_item,
   input  logic                  q_pop
);
   import csl_pkg::*;

   req_item_type slot_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         rp_ff, rp_in, wp_ff, wp_in;
   logic         push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != 2'd0);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rp_ff];

   // pointer and fill count
   always_comb begin
      rp_in  = pop ? !rp_ff : rp_ff;
      wp_in  = push ? !wp_ff : wp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) slot_ff[wp_ff] <= req_item;
   end

endmodule

// ----- hw/rtl/csl_engine.sv -----
// Back end: runs all patterns over the byte buffer and builds tokens.
`include "assert_macros.svh"
module csl_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  csl_pkg::req_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output csl_pkg::rsp_item_type rsp_item
);
   import csl_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_RUN     = 7'b0000010,
      S_EXEC    = 7'b0000100,
      S_OVF     = 7'b0001000,
      S_RESOLVE = 7'b0010000,
      S_ERR     = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [NUM_LITS:1]     lit_ff, lit_in;
   logic [NUM_VARS-1:0]   var_ff, var_in;
   logic [15:0]           cand_ff, cand_in;
   logic [6:0]            bkind_ff, bkind_in;
   logic [15:0]           blen_ff, blen_in;
   logic [31:0]           off_ff, off_in;
   logic [RC_W-1:0]       rc_ff, rc_in;
   logic [BUF_AW-1:0]     head_ff, head_in, mid_ff, mid_in, tail_ff, tail_in;
   logic                  eof_ff, eof_in;
   rsp_item_type          hold_ff, hold_in, out_ff, out_in;
   logic                  hold_v_ff, hold_v_in, out_v_ff, out_v_in;

   logic                  out_free, can_emit, emit, release_hold, start;
   rsp_item_type          emit_item;
   logic                  wr_en;
   logic [BUF_AW-1:0]     rd_addr;
   logic [7:0]            c;
   logic [NUM_LITS:1]     nlit;
   logic [NUM_VARS-1:0]   nvar;
   logic [6:0]            acc;
   logic                  alpha, digit, alnum, octd, hexd, simple;
   logic [15:0]           dropped;
   logic [31:0]           ovf_off;

   // byte buffer: replay region [head, mid), pending bytes [mid, tail)
   assign wr_en   = (state_ff == S_IDLE) && q_valid && (q_item.req_type == REQ_BYTE);
   assign rd_addr = (state_ff == S_RESOLVE || state_ff == S_ERR) ? head_ff : mid_ff;

   csl_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (q_item.data_byte),
      .rd_addr (rd_addr),
      .rd_data (c)
   );

   // character classes
   always_comb begin
      digit  = (c >= "0") && (c <= "9");
      alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
      alnum  = alpha || digit;
      octd   = (c >= "0") && (c <= "7");
      hexd   = digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      simple = (c == "'") || (c == "\"") || (c == "?") || (c == "\\") || (c == "a") ||
               (c == "b") || (c == "f") || (c == "n") || (c == "r") || (c == "t") ||
               (c == "v");
   end

   // pattern step for the current byte
   always_comb begin
      for (int k = 1; k <= NUM_LITS; k++) begin
         nlit[k] = lit_ff[k] && (cand_ff < {12'd0, lit_len(k)}) &&
                   ((lit_byte(k, cand_ff[2:0]) == c) ||
                    ((7'(k) == KIND_BLANK) && (c == 8'h09)));
      end
      nvar = '0;
      nvar[V_ID_B] = (var_ff[V_ID_S] && alpha) || (var_ff[V_ID_B] && alnum);
      nvar[V_IN_B] = (var_ff[V_IN_S] && (c >= "1") && (c <= "9")) ||
                     (var_ff[V_IN_B] && digit);
      nvar[V_CH_Q] = var_ff[V_CH_S] && (c == "'");
      nvar[V_CH_A] = var_ff[V_CH_Q] && alnum;
      nvar[V_CH_D] = var_ff[V_CH_A] && (c == "'");
      nvar[V_ST_D] = var_ff[V_ST_B] && (c == "\"");
      nvar[V_ST_E] = var_ff[V_ST_B] && (c == "\\");
      nvar[V_ST_B] = (var_ff[V_ST_S] && (c == "\"")) ||
                     (var_ff[V_ST_B] && (c != "\"") && (c != "\\") && (c != 8'h0a)) ||
                     (var_ff[V_ST_E] && (simple || octd)) ||
                     (var_ff[V_ST_O1] && octd) || (var_ff[V_ST_O2] && octd) ||
                     ((var_ff[V_ST_X] || var_ff[V_ST_XM]) && hexd) ||
                     (var_ff[V_ST_U + 3] && hexd) || (var_ff[V_ST_U + 7] && hexd);
      nvar[V_ST_O1] = var_ff[V_ST_E] && !simple && octd;
      nvar[V_ST_O2] = var_ff[V_ST_O1] && octd;
      nvar[V_ST_X]  = var_ff[V_ST_E] && !simple && !octd && (c == "x");
      nvar[V_ST_XM] = (var_ff[V_ST_X] || var_ff[V_ST_XM]) && hexd;
      nvar[V_ST_U]  = var_ff[V_ST_E] && !simple && !octd && (c == "u");
      for (int u = 1; u < 8; u++) begin
         nvar[V_ST_U + u] = var_ff[V_ST_U + u - 1] && hexd;
      end
   end

   // accepted kind: lowest literal of exact length, then the others in order
   always_comb begin
      acc = KIND_EOF;
      for (int k = NUM_LITS; k >= 1; k--) begin
         if (nlit[k] && ({12'd0, lit_len(k)} == cand_ff + 16'd1)) acc = 7'(k);
      end
      if (acc == KIND_EOF) begin
         priority if (nvar[V_ID_B]) acc = KIND_IDENT;
         else if (nvar[V_IN_B]) acc = KIND_INT;
         else if (nvar[V_ST_D]) acc = KIND_STRING;
         else if (nvar[V_CH_D]) acc = KIND_CHAR;
         else acc = KIND_EOF;
      end
   end

   assign dropped  = 16'(rc_ff) + 16'd1;
   assign ovf_off  = sat_add(off_ff, {16'd0, dropped});
   assign out_free = !out_v_ff || !rsp_stall;
   assign can_emit = !hold_v_ff || out_free;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      lit_in    = lit_ff;
      var_in    = var_ff;
      cand_in   = cand_ff;
      bkind_in  = bkind_ff;
      blen_in   = blen_ff;
      off_in    = off_ff;
      rc_in     = rc_ff;
      head_in   = head_ff;
      mid_in    = mid_ff;
      tail_in   = tail_ff;
      eof_in    = eof_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      start     = 1'b0;
      release_hold = 1'b0;
      emit_item = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.req_type == REQ_BYTE) tail_in = tail_ff + 1'b1;
               else eof_in = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (mid_ff != tail_ff) begin
               state_in = S_EXEC;
            end else if (eof_ff && (cand_ff != 16'd0)) begin
               state_in = S_RESOLVE;
            end else if (eof_ff) begin
               if (can_emit) begin
                  emit = 1'b1;
                  emit_item.end_offset = off_ff;
                  start    = 1'b1;
                  off_in   = '0;
                  eof_in   = 1'b0;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_EXEC: begin
            if ((nlit == '0) && (nvar == '0)) begin
               state_in = S_RESOLVE;
            end else if (acc != KIND_EOF) begin
               lit_in   = nlit;
               var_in   = nvar;
               cand_in  = (cand_ff == 16'hFFFF) ? cand_ff : cand_ff + 16'd1;
               bkind_in = acc;
               blen_in  = cand_in;
               off_in   = ovf_off;
               rc_in    = '0;
               mid_in   = mid_ff + 1'b1;
               head_in  = mid_ff + 1'b1;
               state_in = S_RUN;
            end else if (32'(rc_ff) >= 32'(REPLAY_DEPTH)) begin
               if (can_emit) begin
                  emit = 1'b1;
                  if (blen_ff != 16'd0) begin
                     emit_item.token_kind   = bkind_ff;
                     emit_item.token_length = blen_ff;
                     emit_item.end_offset   = off_ff;
                     blen_in  = '0;
                     state_in = S_OVF;
                  end else begin
                     emit_item.token_length = dropped;
                     emit_item.end_offset   = ovf_off;
                     emit_item.is_error     = ERR_OVERFLOW;
                     off_in   = ovf_off;
                     start    = 1'b1;
                     mid_in   = mid_ff + 1'b1;
                     head_in  = mid_ff + 1'b1;
                     state_in = S_RUN;
                  end
               end
            end else begin
               lit_in   = nlit;
               var_in   = nvar;
               cand_in  = (cand_ff == 16'hFFFF) ? cand_ff : cand_ff + 16'd1;
               rc_in    = rc_ff + 1'b1;
               mid_in   = mid_ff + 1'b1;
               state_in = S_RUN;
            end
         end
         S_OVF: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_item.token_length = dropped;
               emit_item.end_offset   = ovf_off;
               emit_item.is_error     = ERR_OVERFLOW;
               off_in   = ovf_off;
               start    = 1'b1;
               mid_in   = mid_ff + 1'b1;
               head_in  = mid_ff + 1'b1;
               state_in = S_RUN;
            end
         end
         S_RESOLVE: begin
            if (blen_ff != 16'd0) begin
               if (can_emit) begin
                  emit = 1'b1;
                  emit_item.token_kind   = bkind_ff;
                  emit_item.token_length = blen_ff;
                  emit_item.end_offset   = off_ff;
                  start    = 1'b1;
                  mid_in   = head_ff;
                  state_in = S_RUN;
               end
            end else begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_item.token_length = 16'd1;
               emit_item.end_offset   = sat_add(off_ff, 32'd1);
               emit_item.is_error     = ERR_UNMATCH;
               emit_item.bad_byte     = c;
               off_in   = sat_add(off_ff, 32'd1);
               start    = 1'b1;
               head_in  = head_ff + 1'b1;
               mid_in   = head_ff + 1'b1;
               state_in = S_RUN;
            end
         end
         S_DONE: begin
            if (!hold_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               release_hold = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // fresh attempt
      if (start) begin
         lit_in   = '1;
         var_in   = '0;
         var_in[V_ID_S] = 1'b1;
         var_in[V_IN_S] = 1'b1;
         var_in[V_CH_S] = 1'b1;
         var_in[V_ST_S] = 1'b1;
         rc_in    = '0;
         cand_in  = '0;
         bkind_in = '0;
         blen_in  = '0;
      end
   end

   // result hold stage and output register; the held item learns its last flag
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff && rsp_stall;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      if (emit) begin
         if (hold_v_ff) begin
            out_in      = hold_ff;
            out_in.last = 1'b0;
            out_v_in    = 1'b1;
         end
         hold_in   = emit_item;
         hold_v_in = 1'b1;
      end else if (release_hold) begin
         out_in      = hold_ff;
         out_in.last = 1'b1;
         out_v_in    = 1'b1;
         hold_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         lit_ff    <= '1;
         var_ff    <= NUM_VARS'((1 << V_ID_S) | (1 << V_IN_S) | (1 << V_CH_S) |
                                (1 << V_ST_S));
         cand_ff   <= '0;
         bkind_ff  <= '0;
         blen_ff   <= '0;
         off_ff    <= '0;
         rc_ff     <= '0;
         head_ff   <= '0;
         mid_ff    <= '0;
         tail_ff   <= '0;
         eof_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lit_ff    <= lit_in;
         var_ff    <= var_in;
         cand_ff   <= cand_in;
         bkind_ff  <= bkind_in;
         blen_ff   <= blen_in;
         off_ff    <= off_in;
         rc_ff     <= rc_in;
         head_ff   <= head_in;
         mid_ff    <= mid_in;
         tail_ff   <= tail_in;
         eof_ff    <= eof_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

   `CSL_ASSERT(a_rc_bound, clock, reset, 32'(rc_ff) <= 32'(REPLAY_DEPTH))
   `CSL_ASSERT_IMPL(a_idle_drained, clock, reset, state_ff == S_IDLE, (mid_ff == tail_ff) && !hold_v_ff && !eof_ff)
   `CSL_ASSERT_IMPL(a_replay_span, clock, reset, state_ff == S_RUN, (BUF_AW'(mid_ff - head_ff)) == BUF_AW'(rc_ff))

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the C subset lexer: token predictor, driver and monitor.
`timescale 1ns / 100ps

module tb_top;
   import csl_pkg::*;

   localparam int BUF_BYTES  = REPLAY_DEPTH;
   localparam int MAX_PER_IN = BUF_BYTES + 2;
   localparam int CYCLE_CAP  = 600000;
   localparam int HOLD_LEN   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   c_subset_lexer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // fixed token texts, indexed by kind
   string tok_text[0:78] = '{"", "(", ")", "{", "}", "[", "]", "<", ">",
      "*", "+", "-", "~", "/", "\\", "%", "^", "|", "&", "!", ";", ":", ",", ".", "=", "?",
      "->", "++", "--", "<<", ">>", "<=", ">=", "==", "!=", "&&", "||", "*=", "/=", "%=",
      "+=", "-=", "<<=", ">>=", "&=", "^=", "|=", "...",
      "break", "case", "continue", "default", "char", "do", "else", "enum", "extern",
      "float", "for", "goto", "if", "int", "long", "open", "closed", "return", "short",
      "signed", "sizeof", "static", "struct", "switch", "union", "unsigned", "void",
      "volatile", "while", "\n", " "};

   // lexer state mirror
   logic [78:0] lit_live;
   logic [23:0] var_live;
   logic [7:0]  held_bytes[BUF_BYTES];
   int          held_cnt, run_len, best_kind, best_len, step_results;
   logic [31:0] token_end;
   logic [7:0]  byte_q[$];
   rsp_item_type token_q[$];

   req_item_type stim_q[$];
   int idle_pct = 0, stall_pct = 0;
   int errors = 0, cycles = 0, hold_cnt = 0;
   logic hold_go = 1'b0, hold_used = 1'b0, req_acc = 1'b0;

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction
   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_hexd(logic [7:0] c);
      return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task automatic restart_match();
      lit_live = '0;
      for (int k = 1; k <= 78; k++) lit_live[k] = 1'b1;
      var_live = '0;
      var_live[V_ID_S] = 1'b1;
      var_live[V_IN_S] = 1'b1;
      var_live[V_CH_S] = 1'b1;
      var_live[V_ST_S] = 1'b1;
      held_cnt = 0;
      run_len = 0;
      best_kind = 0;
      best_len = 0;
   endtask

   task automatic add_token(int kind, int len, logic [31:0] fin, logic [1:0] err,
                            logic [7:0] bad);
      rsp_item_type t;
      if (step_results >= MAX_PER_IN) return;
      t.token_kind = 7'(kind);
      t.token_length = 16'(len);
      t.end_offset = fin;
      t.is_error = err;
      t.bad_byte = bad;
      t.last = 1'b0;
      token_q.push_back(t);
      step_results++;
   endtask

   // attempt over: give best token or unmatched error, requeue leftovers
   task automatic close_attempt(bit has_cur, logic [7:0] cur);
      logic [7:0] tmp[$];
      for (int i = 0; i < held_cnt; i++) tmp.push_back(held_bytes[i]);
      if (has_cur) tmp.push_back(cur);
      foreach (byte_q[i]) tmp.push_back(byte_q[i]);
      while (tmp.size() > BUF_BYTES + 1) void'(tmp.pop_back());
      if (best_len > 0) begin
         add_token(best_kind, best_len, token_end, ERR_NONE, 8'd0);
      end else if (tmp.size() > 0) begin
         token_end = add_sat(token_end, 1);
         add_token(KIND_EOF, 1, token_end, ERR_UNMATCH, tmp[0]);
         void'(tmp.pop_front());
      end
      restart_match();
      byte_q = tmp;
   endtask

   task automatic scan_byte(logic [7:0] c);
      logic [78:0] nl;
      logic [23:0] nv;
      int acc;
      int pos;
      nl = '0;
      nv = '0;
      acc = 0;
      pos = run_len;
      for (int k = 1; k <= 78; k++) begin
         if (lit_live[k] && pos < tok_text[k].len())
            if (tok_text[k][pos] == c || (k == 78 && c == 8'h09)) nl[k] = 1'b1;
      end
      if ((var_live[V_ID_S] && is_letter(c)) || (var_live[V_ID_B] && (is_letter(c) || is_dig(c))))
         nv[V_ID_B] = 1'b1;
      if ((var_live[V_IN_S] && c >= "1" && c <= "9") || (var_live[V_IN_B] && is_dig(c)))
         nv[V_IN_B] = 1'b1;
      if (var_live[V_CH_S] && c == "'") nv[V_CH_Q] = 1'b1;
      if (var_live[V_CH_Q] && (is_letter(c) || is_dig(c))) nv[V_CH_A] = 1'b1;
      if (var_live[V_CH_A] && c == "'") nv[V_CH_D] = 1'b1;
      if (var_live[V_ST_S] && c == "\"") nv[V_ST_B] = 1'b1;
      if (var_live[V_ST_B]) begin
         if (c == "\"") nv[V_ST_D] = 1'b1;
         else if (c == "\\") nv[V_ST_E] = 1'b1;
         else if (c != 8'h0a) nv[V_ST_B] = 1'b1;
      end
      // escape sequences inside strings
      if (var_live[V_ST_E]) begin
         if (c inside {"'", "\"", "?", "\\", "a", "b", "f", "n", "r", "t", "v"}) begin
            nv[V_ST_B] = 1'b1;
         end else if (c >= "0" && c <= "7") begin
            nv[V_ST_B] = 1'b1;
            nv[V_ST_O1] = 1'b1;
         end else if (c == "x") begin
            nv[V_ST_X] = 1'b1;
         end else if (c == "u") begin
            nv[V_ST_U] = 1'b1;
         end
      end
      if (var_live[V_ST_O1] && c >= "0" && c <= "7") begin
         nv[V_ST_B] = 1'b1;
         nv[V_ST_O2] = 1'b1;
      end
      if (var_live[V_ST_O2] && c >= "0" && c <= "7") nv[V_ST_B] = 1'b1;
      if ((var_live[V_ST_X] || var_live[V_ST_XM]) && is_hexd(c)) begin
         nv[V_ST_B] = 1'b1;
         nv[V_ST_XM] = 1'b1;
      end
      for (int k = 0; k < 8; k++) begin
         if (var_live[V_ST_U + k] && is_hexd(c)) begin
            if (k == 3 || k == 7) nv[V_ST_B] = 1'b1;
            if (k < 7) nv[V_ST_U + k + 1] = 1'b1;
         end
      end

      if (nl == '0 && nv == '0) begin
         close_attempt(1'b1, c);
         return;
      end
      for (int k = 1; k <= 78 && acc == 0; k++)
         if (nl[k] && tok_text[k].len() == pos + 1) acc = k;
      if (acc == 0) begin
         if (nv[V_ID_B]) acc = KIND_IDENT;
         else if (nv[V_IN_B]) acc = KIND_INT;
         else if (nv[V_ST_D]) acc = KIND_STRING;
         else if (nv[V_CH_D]) acc = KIND_CHAR;
      end
      lit_live = nl;
      var_live = nv;
      if (run_len < 16'hFFFF) run_len++;
      if (acc != 0) begin
         best_kind = acc;
         best_len = run_len;
         token_end = add_sat(token_end, held_cnt + 1);
         held_cnt = 0;
      end else if (held_cnt >= BUF_BYTES) begin
         if (best_len > 0) add_token(best_kind, best_len, token_end, ERR_NONE, 8'd0);
         token_end = add_sat(token_end, held_cnt + 1);
         add_token(KIND_EOF, held_cnt + 1, token_end, ERR_OVERFLOW, 8'd0);
         restart_match();
      end else begin
         held_bytes[held_cnt] = c;
         held_cnt++;
      end
   endtask

   task automatic drain_bytes();
      logic [7:0] c;
      while (byte_q.size() > 0) begin
         c = byte_q.pop_front();
         scan_byte(c);
      end
   endtask

   // work out the tokens one accepted item gives
   task automatic predict_tokens(req_item_type it);
      rsp_item_type t;
      step_results = 0;
      byte_q.delete();
      if (it.req_type == REQ_BYTE) begin
         byte_q.push_back(it.data_byte);
         drain_bytes();
      end else begin
         while (run_len > 0) begin
            close_attempt(1'b0, 8'd0);
            drain_bytes();
         end
         add_token(KIND_EOF, 0, token_end, ERR_NONE, 8'd0);
         token_end = '0;
         restart_match();
      end
      if (step_results > 0) begin
         t = token_q.pop_back();
         t.last = 1'b1;
         token_q.push_back(t);
      end
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) stim_q.push_back({REQ_BYTE, s[i]});
   endtask

   task automatic add_eoi();
      stim_q.push_back({REQ_EOI, 8'($urandom_range(255))});
   endtask

   // random text: mostly well-formed fragments, some noise
   task automatic add_random_text(int n_items, bit with_long);
      string frags[$];
      string s;
      int target;
      frags = '{"int", "while", "unsigned", "volatile", "sizeof", "closed", "open", "x_1",
                "abc9", "Zq", "123", "9", "0", "\"ab\\n\\x4F\\101\\u12AB\"", "\"\\U\"",
                "\"\\u12\"", "\"\\12345678\"", "'a'", "'7", "'", "<<=", ">>=", "...", "..",
                "->", "++", "&&", "||", "!=", "(", ")", "{", "}", "[", "]", ";", ",", "?",
                ":", "~", "\\", "%=", "^", "-", "\n", " ", "\t", "\"open", "\"a\nb\"",
                "elsewhere", "if(", "do"};
      // one string long enough to overflow the replay buffer
      if (with_long) begin
         s = "\"";
         for (int i = 0; i < 34; i++) s = {s, string'(8'($urandom_range(97, 122)))};
         add_text(s);
      end
      target = stim_q.size() + n_items;
      while (stim_q.size() < target) begin
         case ($urandom_range(99)) inside
            [0:7]: stim_q.push_back({REQ_BYTE, 8'($urandom_range(255))});
            [8:10]: add_eoi();
            default: add_text(frags[$urandom_range(frags.size() - 1)]);
         endcase
      end
      add_eoi();
   endtask

   // drive on falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_acc) begin
         if (stim_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_item <= stim_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
   end

   // long receiver hold-off
   always @(negedge clock) begin
      if (hold_go && !hold_used) begin
         hold_cnt <= HOLD_LEN;
         hold_used <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // check tokens, then predict from the accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_acc <= 1'b0;
      end else begin
         req_acc <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (token_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected token: kind %0d len %0d end %0d err %0d bad %0h last %0d",
                           rsp_item.token_kind, rsp_item.token_length, rsp_item.end_offset,
                           rsp_item.is_error, rsp_item.bad_byte, rsp_item.last);
            end else if (rsp_item !== token_q[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp kind %0d len %0d end %0d err %0d bad %0h last %0d / %s",
                           token_q[0].token_kind, token_q[0].token_length,
                           token_q[0].end_offset, token_q[0].is_error, token_q[0].bad_byte,
                           token_q[0].last,
                           $sformatf("got kind %0d len %0d end %0d err %0d bad %0h last %0d",
                                     rsp_item.token_kind, rsp_item.token_length,
                                     rsp_item.end_offset, rsp_item.is_error,
                                     rsp_item.bad_byte, rsp_item.last));
               void'(token_q.pop_front());
            end else begin
               void'(token_q.pop_front());
            end
         end
         if (req_valid && !req_stall) predict_tokens(req_item);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      token_end = '0;
      restart_match();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: keywords, escapes, char literal, lone zero, NUL and 0xFF
      add_text("int x=\"a\\tb\\x4f\\1\\u00e9\";'q' 0 90<<=");
      stim_q.push_back({REQ_BYTE, 8'h00});
      stim_q.push_back({REQ_BYTE, 8'hFF});
      add_text("->.");
      add_eoi();
      add_random_text(15, 1'b1);
      while (stim_q.size() > 0) @(posedge clock);

      idle_pct = 57;
      hold_go = 1'b1;
      add_random_text(15, 1'b0);
      while (stim_q.size() > 0) @(posedge clock);

      idle_pct = 0;
      stall_pct = 57;
      add_random_text(15, 1'b0);
      while (stim_q.size() > 0) @(posedge clock);

      idle_pct = 28;
      stall_pct = 28;
      add_random_text(15, 1'b0);
      while (stim_q.size() > 0 || req_valid) @(posedge clock);

      while (token_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
